// ----- rtl/range_max_argmax_tree_defines.svh -----
// Assertion macros shared by the range maximum tree RTL.
// No dependencies; include by bare file name inside a module body.
`ifndef RANGE_MAX_ARGMAX_TREE_DEFINES_SVH
`define RANGE_MAX_ARGMAX_TREE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RMAT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RMAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/rmat_pkg.sv -----
// Package for the range maximum tree: channel field widths, action codes,
// register reset value. No dependencies.
package rmat_pkg;

	localparam int ACTION_W = 1;
	localparam int POS_W    = 10;
	localparam int VAL_W    = 31;
	localparam int IDX_W    = 10;
	localparam int COUNT_W  = 11;

	localparam logic [ACTION_W-1:0] ACT_WRITE = 1'b0;
	localparam logic [ACTION_W-1:0] ACT_QUERY = 1'b1;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

endpackage

// ----- rtl/rmat_if.sv -----
// Channel interfaces of the range maximum tree: request, response, config write.
// Depends on rmat_pkg.
interface rmat_req_if;
	import rmat_pkg::*;
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [POS_W-1:0]    position;
	logic [VAL_W-1:0]    value;
	logic [POS_W-1:0]    query_left;
	logic [POS_W-1:0]    query_right;

	modport source (output valid, action, position, value, query_left, query_right,
		input ready);
	modport sink (input valid, action, position, value, query_left, query_right,
		output ready);
endinterface

interface rmat_rsp_if;
	import rmat_pkg::*;
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] max_value;
	logic [IDX_W-1:0] max_index;
	logic             found;

	modport source (output valid, max_value, max_index, found, input ready);
	modport sink (input valid, max_value, max_index, found, output ready);
endinterface

interface rmat_cfg_if;
	import rmat_pkg::*;
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- rtl/range_max_argmax_tree.sv -----
// Range maximum / leftmost arg-max over a binary max tree held in one node memory.
// Depends on rmat_pkg, the interfaces in rmat_if.sv and range_max_argmax_tree_defines.svh.
//
//  channel | modport | payload                                        | transaction
//  --------+---------+------------------------------------------------+-------------------
//  req     | sink    | action, position, value, query_left/right      | one write or query
//  rsp     | source  | max_value, max_index, found                    | one query result
//  cfg     | sink    | data (element_count)                           | one register write
//
// Walks: a leaf write climbs one tree level per cycle, bound by the single read port
// fetching the sibling node. A query visits the low-side node and then the high-side node
// of each level it walks, since each level may need two node reads through that one port.
// Reset: a clearing pass zeroes all 2*DEPTH nodes, one per cycle; req.ready stays low
// until it ends. cfg is always ready.
// Stalls: a finished result waits in the output register; writes keep flowing meanwhile,
// and a query holds its last step until the output register is free.
module range_max_argmax_tree #(
	parameter int DEPTH      = 1024,
	parameter int VALUE_BITS = 31
) (
	input  logic       clk,
	input  logic       arst_n,
	rmat_req_if.sink   req,
	rmat_rsp_if.source rsp,
	rmat_cfg_if.sink   cfg
);
	import rmat_pkg::*;
	`include "range_max_argmax_tree_defines.svh"

	localparam int NODE_CNT = 2 * DEPTH;
	localparam int NODE_W   = $clog2(DEPTH) + 1;   // node address
	localparam int HI_W     = NODE_W + 1;          // walk bound, may reach 2*DEPTH
	localparam int VW       = (VALUE_BITS > VAL_W) ? VAL_W : VALUE_BITS;
	localparam int WIN_W    = (DEPTH > 1024) ? IDX_W : $clog2(DEPTH);

	typedef struct packed {
		logic [VW-1:0]    mx;
		logic [WIN_W-1:0] win;
	} node_t;

	typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_UPD, S_QRY} state_t;

	// Right child wins on a larger value or on an equal value with a smaller index.
	function automatic node_t pick(node_t a, node_t b);
		if (b.mx > a.mx || (b.mx == a.mx && b.win < a.win))
			return b;
		return a;
	endfunction

	// Fold one node into the running best; zero never counts.
	function automatic node_t take(node_t best, node_t n);
		if (n.mx > best.mx || (n.mx == best.mx && n.mx != '0 && n.win < best.win))
			return n;
		return best;
	endfunction

	state_t             state_q;
	logic [COUNT_W-1:0] elem_cnt_q;
	logic [NODE_W-1:0]  clr_q;
	logic [NODE_W-1:0]  node_q;
	node_t              cur_q;
	logic [HI_W-1:0]    lo_q;
	logic [HI_W-1:0]    hi_q;
	logic               phase_q;
	logic               pend_q;
	node_t              best_q;
	logic               out_vld_q;
	logic [VAL_W-1:0]   out_val_q;
	logic [IDX_W-1:0]   out_idx_q;
	logic               out_fnd_q;

	// node memory
	node_t              mem [NODE_CNT];
	node_t              rd_q;
	logic               mem_we;
	logic [NODE_W-1:0]  mem_waddr;
	node_t              mem_wdata;
	logic               mem_re;
	logic [NODE_W-1:0]  mem_raddr;

	logic               req_fire;
	logic               wr_ok;
	logic               rng_ok;
	logic [NODE_W-1:0]  leaf;
	node_t              leaf_node;
	logic [NODE_W-1:0]  par;
	node_t              comb;
	node_t              best_next;
	logic               out_free;
	logic               out_set;
	logic               lo_take;
	logic               hi_take;
	logic               walk_on;

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	assign rsp.valid     = out_vld_q;
	assign rsp.max_value = out_val_q;
	assign rsp.max_index = out_idx_q;
	assign rsp.found     = out_fnd_q;
	assign out_free      = !out_vld_q || rsp.ready;

	// Drop writes past the store; bound queries by element_count and by DEPTH.
	assign wr_ok  = 32'(req.position) < 32'(DEPTH);
	assign rng_ok = (req.query_left <= req.query_right) &&
		({1'b0, req.query_right} < elem_cnt_q) &&
		(32'(req.query_right) < 32'(DEPTH));

	assign leaf          = NODE_W'(req.position) + NODE_W'(DEPTH);
	assign leaf_node.mx  = req.value[VW-1:0];
	assign leaf_node.win = WIN_W'(req.position);

	// Update walk: node_q is the child just written, rd_q its sibling.
	assign par  = node_q >> 1;
	assign comb = node_q[0] ? pick(rd_q, cur_q) : pick(cur_q, rd_q);

	assign best_next = pend_q ? take(best_q, rd_q) : best_q;
	assign walk_on   = lo_q < hi_q;
	assign lo_take   = walk_on && lo_q[0];
	assign hi_take   = hi_q[0];

	// Load the output register when a finished query finds it free.
	assign out_set = (state_q == S_QRY) && !phase_q && !walk_on && out_free;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			S_IDLE: begin
				// store the leaf and fetch its sibling in the same cycle
				if (req_fire && req.action == ACT_WRITE && wr_ok) begin
					mem_we    = 1'b1;
					mem_waddr = leaf;
					mem_wdata = leaf_node;
					mem_re    = 1'b1;
					mem_raddr = leaf ^ NODE_W'(1);
				end
			end
			S_UPD: begin
				mem_we    = 1'b1;
				mem_waddr = par;
				mem_wdata = comb;
				if (par != NODE_W'(1)) begin
					mem_re    = 1'b1;
					mem_raddr = par ^ NODE_W'(1);
				end
			end
			S_QRY: begin
				if (!phase_q && lo_take) begin
					mem_re    = 1'b1;
					mem_raddr = lo_q[NODE_W-1:0];
				end else if (phase_q && hi_take) begin
					mem_re    = 1'b1;
					mem_raddr = hi_q[NODE_W-1:0] - NODE_W'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rd_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			elem_cnt_q <= COUNT_RESET;
			clr_q      <= '0;
			out_vld_q  <= 1'b0;
			pend_q     <= 1'b0;
			phase_q    <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready)
				elem_cnt_q <= cfg.data;
			if (out_set)
				out_vld_q <= 1'b1;
			else if (rsp.ready)
				out_vld_q <= 1'b0;

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + NODE_W'(1);
					if (clr_q == NODE_W'(NODE_CNT - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_fire) begin
						if (req.action == ACT_QUERY) begin
							// invalid ranges walk nothing and report not found
							if (rng_ok) begin
								lo_q <= HI_W'(req.query_left) + HI_W'(DEPTH);
								hi_q <= HI_W'(req.query_right) + HI_W'(DEPTH + 1);
							end else begin
								lo_q <= '0;
								hi_q <= '0;
							end
							best_q  <= '0;
							pend_q  <= 1'b0;
							phase_q <= 1'b0;
							state_q <= S_QRY;
						end else if (wr_ok) begin
							node_q  <= leaf;
							cur_q   <= leaf_node;
							state_q <= S_UPD;
						end
					end
				end
				S_UPD: begin
					node_q <= par;
					cur_q  <= comb;
					if (par == NODE_W'(1))
						state_q <= S_IDLE;
				end
				S_QRY: begin
					best_q <= best_next;
					pend_q <= mem_re;
					if (!phase_q) begin
						if (walk_on) begin
							if (lo_take)
								lo_q <= lo_q + HI_W'(1);
							phase_q <= 1'b1;
						end else if (out_free) begin
							// finish: fold the last read straight into the result
							out_fnd_q <= best_next.mx != '0;
							out_val_q <= (best_next.mx != '0) ? VAL_W'(best_next.mx) : '0;
							out_idx_q <= (best_next.mx != '0) ? IDX_W'(best_next.win) : '0;
							state_q   <= S_IDLE;
						end
					end else begin
						// odd hi: (hi - 1) >> 1 equals hi >> 1
						lo_q    <= lo_q >> 1;
						hi_q    <= hi_q >> 1;
						phase_q <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`RMAT_ASSERT_NOW(a_no_rw_clash, clk, arst_n, mem_we && mem_re, mem_waddr != mem_raddr, "node read and write hit the same entry")
	`RMAT_ASSERT_NOW(a_no_root_zero, clk, arst_n, mem_we && state_q != S_CLEAR, mem_waddr != '0, "tree walk wrote unused node zero")
	`RMAT_ASSERT_NEXT(a_query_busy, clk, arst_n, req_fire && req.action == ACT_QUERY, !req.ready, "query accepted without leaving idle")
	`RMAT_ASSERT_NOW(a_rsp_from_query, clk, arst_n, $rose(out_vld_q), $past(state_q == S_QRY), "result appeared outside a query")
	`RMAT_ASSERT_NOW(a_found_nonzero, clk, arst_n, rsp.valid && rsp.found, rsp.max_value != '0, "found flagged with zero maximum")

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking bench for range_max_argmax_tree: leaf writes, range max queries
// and element_count writes, checked against a leaf-store model kept in the bench.
// Depends on rmat_pkg, the channel interfaces in rmat_if.sv and the block's RTL.
module tb;
	import rmat_pkg::*;

	localparam int TREE_DEPTH      = 1024;
	localparam int HALF_PERIOD     = 4;
	localparam int RESET_CYCLES    = 12;
	// A leaf write walks up to the root and a query walks its range up the tree; leave room for both.
	localparam int DRAIN_CYCLES    = 40;
	// The clearing pass after reset keeps req.ready low while it zeroes every node.
	localparam int WATCHDOG_LIMIT  = 20000;

	typedef struct packed {
		logic [VAL_W-1:0] max_value;
		logic [IDX_W-1:0] max_index;
		logic             found;
	} range_result_t;

	logic clk = 1'b0;
	logic arst_n;

	rmat_req_if req_ch ();
	rmat_rsp_if rsp_ch ();
	rmat_cfg_if cfg_ch ();

	range_max_argmax_tree #(
		.DEPTH      (TREE_DEPTH),
		.VALUE_BITS (VAL_W)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always #HALF_PERIOD clk = ~clk;

	// Bench copy of the block's state: the leaves are enough, since every tree node
	// is just the maximum of the leaves under it with the leftmost position winning.
	logic [VAL_W-1:0]   leaf_value [TREE_DEPTH];
	logic [COUNT_W-1:0] element_count;

	// Results owed by the block, oldest first.
	range_result_t expected_maxima [$];

	int sender_idle_pct   = 0;
	int receiver_stall_pct = 0;
	int mismatch_count    = 0;
	int leaf_writes       = 0;
	int range_queries     = 0;
	int results_checked   = 0;
	int results_found     = 0;
	int count_settings    = 0;
	int quiet_cycles      = 0;

	// Leftmost position of the largest positive value in left..right, or all zero
	// when the range is empty, lies past element_count, or holds nothing positive.
	function automatic range_result_t range_maximum(logic [POS_W-1:0] left,
		logic [POS_W-1:0] right);
		range_result_t res;
		int limit;
		res = '0;
		limit = (element_count > TREE_DEPTH) ? TREE_DEPTH : int'(element_count);
		if (left <= right && int'(right) < limit) begin
			for (int p = left; p <= right; p++) begin
				// Strictly greater keeps the first position on equal values.
				if (leaf_value[p] > res.max_value) begin
					res.max_value = leaf_value[p];
					res.max_index = p[IDX_W-1:0];
				end
			end
		end
		res.found = (res.max_value != '0);
		return res;
	endfunction

	// Present one request transaction and hold it until the block takes it. The sender
	// idles with the phase's probability at each falling edge before the item goes out.
	task automatic send_item(input logic [ACTION_W-1:0] act, input logic [POS_W-1:0] pos,
		input logic [VAL_W-1:0] val, input logic [POS_W-1:0] left,
		input logic [POS_W-1:0] right);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid       = 1'b1;
		req_ch.action      = act;
		req_ch.position    = pos;
		req_ch.value       = val;
		req_ch.query_left  = left;
		req_ch.query_right = right;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		// Accepted at this edge: advance the bench state in the same order as the block.
		if (act == ACT_WRITE) begin
			leaf_value[pos] = val;
			leaf_writes++;
		end else begin
			expected_maxima.push_back(range_maximum(left, right));
			range_queries++;
		end
	endtask

	// Query fields ride along as junk on a write; position and value do on a query.
	task automatic write_leaf(input int pos, input logic [VAL_W-1:0] val);
		send_item(ACT_WRITE, pos[POS_W-1:0], val, POS_W'($urandom), POS_W'($urandom));
	endtask

	task automatic ask_range(input int left, input int right);
		send_item(ACT_QUERY, POS_W'($urandom), VAL_W'($urandom), left[POS_W-1:0],
			right[POS_W-1:0]);
	endtask

	// Drop valid, wait for every owed result, then give trailing writes time to land.
	task automatic settle_block();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (expected_maxima.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Change element_count only while the block is idle.
	task automatic set_element_count(input int count);
		settle_block();
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.data  = count[COUNT_W-1:0];
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		element_count = count[COUNT_W-1:0];
		count_settings++;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// One random transaction: mostly writes inside the active positions and
	// well-formed queries, with some noise that lands anywhere.
	task automatic random_item();
		int lim;
		int pos;
		int left;
		int right;
		int pick;
		logic [VAL_W-1:0] val;
		lim = (element_count == 0 || element_count > TREE_DEPTH) ? TREE_DEPTH
			: int'(element_count);
		if ($urandom_range(99) < 45) begin
			pick = $urandom_range(99);
			// Small values make equal maxima, and so leftmost-winner ties, common.
			if (pick < 30)
				val = VAL_W'($urandom_range(4, 1));
			else if (pick < 40)
				val = '0;
			else if (pick < 48)
				val = '1;
			else
				val = VAL_W'($urandom);
			if ($urandom_range(99) < 85)
				pos = $urandom_range(lim - 1, 0);
			else
				pos = $urandom_range(TREE_DEPTH - 1, 0);
			write_leaf(pos, val);
		end else begin
			if ($urandom_range(99) < 75) begin
				left = $urandom_range(lim - 1, 0);
				if ($urandom_range(99) < 30)
					right = left + $urandom_range((lim - 1 - left < 7) ? lim - 1 - left : 7, 0);
				else
					right = $urandom_range(lim - 1, left);
			end else begin
				left  = $urandom_range(TREE_DEPTH - 1, 0);
				right = $urandom_range(TREE_DEPTH - 1, 0);
			end
			ask_range(left, right);
		end
	endtask

	// Receiver: stall at each falling edge with the phase's probability.
	always @(negedge clk)
		rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);

	// Check each result transaction against the oldest owed one.
	always @(posedge clk) begin
		range_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_maxima.size() == 0) begin
				$error("unexpected result: max_value %0d max_index %0d found %0d",
					rsp_ch.max_value, rsp_ch.max_index, rsp_ch.found);
				mismatch_count++;
			end else begin
				want = expected_maxima.pop_front();
				results_checked++;
				if (want.found)
					results_found++;
				if (rsp_ch.max_value !== want.max_value) begin
					$error("max_value: expected %0d, actual %0d", want.max_value,
						rsp_ch.max_value);
					mismatch_count++;
				end
				if (rsp_ch.max_index !== want.max_index) begin
					$error("max_index: expected %0d, actual %0d", want.max_index,
						rsp_ch.max_index);
					mismatch_count++;
				end
				if (rsp_ch.found !== want.found) begin
					$error("found: expected %0d, actual %0d", want.found, rsp_ch.found);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: end the run when no channel moves a transaction for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// A freshly cleared tree holds nothing positive anywhere.
	task automatic test_cleared_tree();
		ask_range(0, TREE_DEPTH - 1);
	endtask

	// Largest value at the last position, smallest positive value at the first.
	task automatic test_field_extremes();
		write_leaf(TREE_DEPTH - 1, '1);
		write_leaf(0, VAL_W'(1));
		ask_range(0, TREE_DEPTH - 1);
		ask_range(0, 0);
		ask_range(TREE_DEPTH - 1, TREE_DEPTH - 1);
	endtask

	// Equal maxima: the lower position must win, on both sides of a tree split.
	task automatic test_leftmost_tie();
		write_leaf(5, VAL_W'(9));
		write_leaf(700, VAL_W'(9));
		ask_range(1, TREE_DEPTH - 2);
		ask_range(6, TREE_DEPTH - 2);
	endtask

	// Empty ranges, bounds past element_count, a leaf stored beyond the bound,
	// an oversized count and a count of zero.
	task automatic test_rejected_ranges();
		ask_range(10, 3);
		set_element_count(600);
		ask_range(0, 600);
		ask_range(0, 599);
		write_leaf(900, VAL_W'(77));
		set_element_count(COUNT_RESET);
		ask_range(900, 900);
		set_element_count(2047);
		ask_range(0, TREE_DEPTH - 1);
		set_element_count(0);
		ask_range(0, 0);
		set_element_count(COUNT_RESET);
	endtask

	// Overwriting with zero removes a leaf from the running.
	task automatic test_zero_values();
		write_leaf(0, '0);
		ask_range(0, 4);
	endtask

	task automatic test_random_traffic(input int items, input int count, input int idle_pct,
		input int stall_pct);
		set_element_count(count);
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		repeat (items) random_item();
		settle_block();
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
	endtask

	initial begin
		// Hold every request and config input at a known value from time zero.
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.action      = ACT_WRITE;
		req_ch.position    = '0;
		req_ch.value       = '0;
		req_ch.query_left  = '0;
		req_ch.query_right = '0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.data        = '0;
		element_count      = COUNT_RESET;
		foreach (leaf_value[i])
			leaf_value[i] = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_cleared_tree();
		test_field_extremes();
		test_leftmost_tie();
		test_rejected_ranges();
		test_zero_values();

		// Random phases: idle patterns on either side, counts at both extremes.
		test_random_traffic(330, TREE_DEPTH, 0, 0);
		test_random_traffic(100, 1, 71, 0);
		test_random_traffic(300, TREE_DEPTH, 71, 0);
		test_random_traffic(300, $urandom_range(TREE_DEPTH - 1, 2), 0, 71);
		test_random_traffic(200, 16, 8, 8);
		test_random_traffic(250, 2047, 0, 0);
		test_random_traffic(50, 0, 8, 8);

		settle_block();
		$display("Covered %0d leaf writes and %0d range queries over %0d element_count writes.",
			leaf_writes, range_queries, count_settings);
		$display("Checked %0d query results, %0d of them with a positive maximum.",
			results_checked, results_found);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/rmat_pkg.sv
rtl/rmat_if.sv
rtl/range_max_argmax_tree.sv
tb/sv/tb.sv
